>>> rtl/core/kss_pkg.sv
`timescale 1ns / 1ps

package kss_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int CAPACITY = MAX_ROWS * MAX_COLS;

    localparam int DATA_W = 32;
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DIM_W = 5;
    localparam int K_W = 9;
    localparam int LIN_W = ROW_W + DIM_W + 1;

    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] NO_RESULT = -32'sd1;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_K = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
    } heap_entry_t;

    typedef struct packed {
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nc;
        logic [K_W-1:0]   k;
    } sel_cfg_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] result;
    } sel_status_t;

endpackage

>>> rtl/core/kss_select.sv
`timescale 1ns / 1ps

module kss_select
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  kss_pkg::sel_cfg_t                 cfg,
    input  logic                              done_ack,
    output logic [kss_pkg::ADDR_W-1:0]        mat_raddr,
    input  logic signed [kss_pkg::DATA_W-1:0] mat_rdata,
    output kss_pkg::sel_status_t              status
);

    typedef enum logic [12:0]
    {
        ST_IDLE     = 13'b0000000000001,
        ST_FILL_RD  = 13'b0000000000010,
        ST_FILL_WR  = 13'b0000000000100,
        ST_SIFT_LD  = 13'b0000000001000,
        ST_SIFT_CUR = 13'b0000000010000,
        ST_RD_L     = 13'b0000000100000,
        ST_CMP_L    = 13'b0000001000000,
        ST_CMP_R    = 13'b0000010000000,
        ST_STORE    = 13'b0000100000000,
        ST_POP_RD   = 13'b0001000000000,
        ST_POP_TOP  = 13'b0010000000000,
        ST_POP_MAT  = 13'b0100000000000,
        ST_DONE     = 13'b1000000000000
    } state_t;

    localparam int HEAP_DEPTH = kss_pkg::MAX_COLS;

    state_t state_reg, state_next;
    logic [kss_pkg::COL_W-1:0] idx_reg, idx_next;
    logic [kss_pkg::COL_W-1:0] pos_reg, pos_next;
    logic [kss_pkg::COL_W-1:0] best_idx_reg, best_idx_next;
    logic [kss_pkg::K_W-1:0] k_reg, k_next;
    logic build_reg, build_next;
    kss_pkg::heap_entry_t cur_reg, cur_next;
    kss_pkg::heap_entry_t best_reg, best_next;
    logic signed [kss_pkg::DATA_W-1:0] res_reg, res_next;

    kss_pkg::heap_entry_t heap_mem [HEAP_DEPTH];
    kss_pkg::heap_entry_t heap_rdata_reg;
    logic [kss_pkg::COL_W-1:0] heap_raddr;
    logic [kss_pkg::COL_W-1:0] heap_waddr;
    kss_pkg::heap_entry_t heap_wdata;
    logic heap_we;

    logic [kss_pkg::COL_W:0] lc;
    logic [kss_pkg::COL_W+1:0] rc;
    logic lc_ok;
    logic rc_ok;
    logic cmp_gt;
    logic [kss_pkg::ROW_W-1:0] row_p1;
    logic row_ok;
    logic [kss_pkg::LIN_W-1:0] pop_lin;

    assign lc = {pos_reg, 1'b1};
    assign rc = {1'b0, pos_reg, 1'b0} + (kss_pkg::COL_W+2)'(2);
    assign lc_ok = (kss_pkg::DIM_W'(lc) < cfg.nc);
    assign rc_ok = (rc < (kss_pkg::COL_W+2)'(cfg.nc));

    // Shared compare unit for every sift step.
    assign cmp_gt = (best_reg.value > heap_rdata_reg.value);

    assign row_p1 = heap_rdata_reg.row + kss_pkg::ROW_W'(1);
    assign row_ok = (kss_pkg::DIM_W'(row_p1) < cfg.nr);
    assign pop_lin = kss_pkg::LIN_W'(row_p1) * kss_pkg::LIN_W'(cfg.nc)
                   + kss_pkg::LIN_W'(heap_rdata_reg.col);

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rdata_reg <= heap_mem[heap_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        best_idx_next = best_idx_reg;
        k_next = k_reg;
        build_next = build_reg;
        cur_next = cur_reg;
        best_next = best_reg;
        res_next = res_reg;
        heap_raddr = '0;
        heap_waddr = pos_reg;
        heap_wdata = cur_reg;
        heap_we = 1'b0;
        mat_raddr = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    res_next = kss_pkg::NO_RESULT;
                    k_next = cfg.k;
                    build_next = 1'b0;
                    state_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD:
            begin
                mat_raddr = kss_pkg::ADDR_W'(idx_reg);
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                heap_we = 1'b1;
                heap_waddr = idx_reg;
                heap_wdata.value = mat_rdata;
                heap_wdata.row = '0;
                heap_wdata.col = idx_reg;
                if (kss_pkg::DIM_W'(idx_reg) == cfg.nc - kss_pkg::DIM_W'(1))
                begin
                    idx_next = kss_pkg::COL_W'(cfg.nc >> 1);
                    build_next = 1'b1;
                    state_next = ST_SIFT_LD;
                end
                else
                begin
                    idx_next = idx_reg + kss_pkg::COL_W'(1);
                    state_next = ST_FILL_RD;
                end
            end
            ST_SIFT_LD:
            begin
                heap_raddr = idx_reg;
                pos_next = idx_reg;
                state_next = ST_SIFT_CUR;
            end
            ST_SIFT_CUR:
            begin
                cur_next = heap_rdata_reg;
                state_next = ST_RD_L;
            end
            ST_RD_L:
            begin
                best_next = cur_reg;
                best_idx_next = pos_reg;
                heap_raddr = lc[kss_pkg::COL_W-1:0];
                state_next = lc_ok ? ST_CMP_L : ST_STORE;
            end
            ST_CMP_L:
            begin
                if (cmp_gt)
                begin
                    best_next = heap_rdata_reg;
                    best_idx_next = lc[kss_pkg::COL_W-1:0];
                end
                heap_raddr = rc[kss_pkg::COL_W-1:0];
                state_next = rc_ok ? ST_CMP_R : ST_STORE;
            end
            ST_CMP_R:
            begin
                if (cmp_gt)
                begin
                    best_next = heap_rdata_reg;
                    best_idx_next = rc[kss_pkg::COL_W-1:0];
                end
                state_next = ST_STORE;
            end
            ST_STORE:
            begin
                heap_we = 1'b1;
                if (best_idx_reg == pos_reg)
                begin
                    heap_wdata = cur_reg;
                    if (build_reg)
                    begin
                        if (idx_reg == '0)
                        begin
                            build_next = 1'b0;
                            state_next = ST_POP_RD;
                        end
                        else
                        begin
                            idx_next = idx_reg - kss_pkg::COL_W'(1);
                            state_next = ST_SIFT_LD;
                        end
                    end
                    else
                    begin
                        k_next = k_reg - kss_pkg::K_W'(1);
                        state_next = ST_POP_RD;
                    end
                end
                else
                begin
                    heap_wdata = best_reg;
                    pos_next = best_idx_reg;
                    state_next = ST_RD_L;
                end
            end
            ST_POP_RD:
            begin
                heap_raddr = '0;
                state_next = (k_reg == '0) ? ST_DONE : ST_POP_TOP;
            end
            ST_POP_TOP:
            begin
                res_next = heap_rdata_reg.value;
                pos_next = '0;
                cur_next.col = heap_rdata_reg.col;
                if (row_ok)
                begin
                    mat_raddr = pop_lin[kss_pkg::ADDR_W-1:0];
                    cur_next.value = heap_rdata_reg.value;
                    cur_next.row = row_p1;
                    state_next = ST_POP_MAT;
                end
                else
                begin
                    cur_next.value = kss_pkg::INT_MAX;
                    cur_next.row = kss_pkg::ROW_W'(cfg.nr);
                    state_next = ST_RD_L;
                end
            end
            ST_POP_MAT:
            begin
                cur_next.value = mat_rdata;
                state_next = ST_RD_L;
            end
            ST_DONE:
            begin
                if (done_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            pos_reg <= '0;
            best_idx_reg <= '0;
            k_reg <= '0;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
            best_idx_reg <= best_idx_next;
            k_reg <= k_next;
            build_reg <= build_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        best_reg <= best_next;
        res_reg <= res_next;
    end

    assign status.done = (state_reg == ST_DONE);
    assign status.result = res_reg;

endmodule

>>> rtl/core/kth_smallest_sorted_matrix.sv
`timescale 1ns / 1ps

// Finds the k-th smallest value of a matrix whose columns are sorted ascending.
// Matrix elements arrive one word per cycle on the input channel in row-major
// order, and each within the memory capacity is written straight into the
// element memory. The word that carries last_element starts the selection;
// the block then drops in_ready until the selection is finished and its result
// sits in the output register. Selection runs on one shared compare unit
// under a small sequencer: it copies the first row into the heap, builds
// the heap, and then makes k pops, each followed by a sift; the last pop
// gives the result. Ordinary words are taken back to back, also while a
// result waits for out_ready. A result that is not taken holds in the
// output register; the next selection cannot finish until it leaves.
// Configuration is to be written over the APB port only while the block is
// idle; the block itself does not enforce this. Reset sets rows, columns
// and k to 1 and empties the load counter; the element memory is not
// cleared.
module kth_smallest_sorted_matrix
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [kss_pkg::DATA_W-1:0] element_value,
    input  logic                              last_element,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [kss_pkg::DATA_W-1:0] kth_value
);

    logic [kss_pkg::DIM_W-1:0] rows_reg;
    logic [kss_pkg::DIM_W-1:0] cols_reg;
    logic [kss_pkg::K_W-1:0] k_reg;
    logic [kss_pkg::CNT_W-1:0] load_cnt_reg, load_cnt_next;
    logic busy_reg, busy_next;
    logic out_valid_reg, out_valid_next;
    logic signed [kss_pkg::DATA_W-1:0] kth_value_reg;

    logic signed [kss_pkg::DATA_W-1:0] mat_mem [kss_pkg::CAPACITY];
    logic signed [kss_pkg::DATA_W-1:0] mat_rdata_reg;
    logic [kss_pkg::ADDR_W-1:0] mat_raddr;

    logic cfg_write;
    logic in_fire;
    logic store_en;
    logic done_ack;
    kss_pkg::sel_cfg_t sel_cfg;
    kss_pkg::sel_status_t sel_status;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= kss_pkg::DIM_W'(1);
            cols_reg <= kss_pkg::DIM_W'(1);
            k_reg <= kss_pkg::K_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                kss_pkg::REG_ROWS: rows_reg <= pwdata[kss_pkg::DIM_W-1:0];
                kss_pkg::REG_COLS: cols_reg <= pwdata[kss_pkg::DIM_W-1:0];
                kss_pkg::REG_K:    k_reg <= pwdata[kss_pkg::K_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            kss_pkg::REG_ROWS: prdata = 32'(rows_reg);
            kss_pkg::REG_COLS: prdata = 32'(cols_reg);
            kss_pkg::REG_K:    prdata = 32'(k_reg);
            default:           prdata = '0;
        endcase
    end

    // A dimension of zero counts as one, and anything above the maximum as the maximum.
    always_comb
    begin
        if (rows_reg == '0)
        begin
            sel_cfg.nr = kss_pkg::DIM_W'(1);
        end
        else if (rows_reg > kss_pkg::DIM_W'(kss_pkg::MAX_ROWS))
        begin
            sel_cfg.nr = kss_pkg::DIM_W'(kss_pkg::MAX_ROWS);
        end
        else
        begin
            sel_cfg.nr = rows_reg;
        end
        if (cols_reg == '0)
        begin
            sel_cfg.nc = kss_pkg::DIM_W'(1);
        end
        else if (cols_reg > kss_pkg::DIM_W'(kss_pkg::MAX_COLS))
        begin
            sel_cfg.nc = kss_pkg::DIM_W'(kss_pkg::MAX_COLS);
        end
        else
        begin
            sel_cfg.nc = cols_reg;
        end
        sel_cfg.k = k_reg;
    end

    assign in_ready = !busy_reg;
    assign in_fire = in_valid && in_ready;
    assign store_en = in_fire && (load_cnt_reg < kss_pkg::CNT_W'(kss_pkg::CAPACITY));
    assign done_ack = sel_status.done && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mat_mem[load_cnt_reg[kss_pkg::ADDR_W-1:0]] <= element_value;
        end
        mat_rdata_reg <= mat_mem[mat_raddr];
    end

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        busy_next = busy_reg;
        out_valid_next = out_valid_reg;
        if (store_en)
        begin
            load_cnt_next = load_cnt_reg + kss_pkg::CNT_W'(1);
        end
        if (in_fire && last_element)
        begin
            load_cnt_next = '0;
            busy_next = 1'b1;
        end
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (done_ack)
        begin
            busy_next = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_ack)
        begin
            kth_value_reg <= sel_status.result;
        end
    end

    kss_select u_select
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_fire && last_element),
        .cfg       (sel_cfg),
        .done_ack  (done_ack),
        .mat_raddr (mat_raddr),
        .mat_rdata (mat_rdata_reg),
        .status    (sel_status)
    );

    assign out_valid = out_valid_reg;
    assign kth_value = kth_value_reg;

    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_element |=> !in_ready)
        else $error("input still ready after the last word was taken");

    a_done_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sel_status.done |-> busy_reg)
        else $error("selection finished while no run was active");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(busy_reg))
        else $error("result appeared without a selection run");

    a_load_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg <= kss_pkg::CNT_W'(kss_pkg::CAPACITY))
        else $error("load counter ran past the memory size");

endmodule
